FILE: sv/sawc_pkg.sv
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types, codes and constants of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sawc_pkg;

    localparam int DEF_MAX_SETS        = 16;
    localparam int DEF_MAX_WAYS        = 4;
    localparam int DEF_MAX_BLOCK_BYTES = 16;
    localparam int DEF_MEM_BYTES       = 65536;

    localparam int TAG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SETS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 2'd2;

    localparam logic [4:0] SETS_RESET  = 5'd1;
    localparam logic [2:0] WAYS_RESET  = 3'd1;
    localparam logic [4:0] BLOCK_RESET = 5'd2;

    // address width that still works for a depth of one
    function automatic int clog2w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PRELOAD = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [15:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        hit;
        logic        replaced_valid;
        logic        wrote_back;
        logic [15:0] victim_block_address;
        logic [1:0]  way_used;
    } out_item_t;

    typedef enum logic [2:0] {
        DIV_BLOCK = 3'd0,
        DIV_SET   = 3'd1,
        DIV_PRE   = 3'd2,
        DIV_FILL  = 3'd3,
        DIV_VICT  = 3'd4
    } div_sel_t;

    typedef enum logic [1:0] {
        SRC_RAM = 2'd0,
        SRC_LO  = 2'd1,
        SRC_HI  = 2'd2
    } data_sel_t;

    typedef enum logic [1:0] {
        BA_CNT  = 2'd0,
        BA_OFF  = 2'd1,
        BA_OFF2 = 2'd2
    } byte_sel_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_PL_DIV, S_PL_WAIT, S_PL_WR0, S_PL_WR1,
        S_BLK_DIV, S_BLK_WAIT, S_SET_DIV, S_SET_WAIT,
        S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_BRANCH,
        S_VT_RD, S_VT_MUL1, S_VT_MUL2, S_VT_DIV, S_VT_WAIT,
        S_WB_RD, S_WB_WR,
        S_FL_DIV, S_FL_WAIT, S_FL_RD, S_FL_WR, S_FL_END,
        S_ACC, S_RD1, S_RD2, S_WR1, S_DONE
    } state_t;

    typedef struct packed {
        logic      load_in;
        logic      div_start;
        div_sel_t  div_sel;
        logic      srch_cmp;
        logic      decide;
        logic      vt_mul1;
        logic      vt_mul2;
        byte_sel_t byte_sel;
        logic      line_wr;
        data_sel_t line_src;
        logic      mem_wr;
        data_sel_t mem_src;
        logic      walk_step;
        logic      fill_commit;
        logic      set_dirty;
        logic      rd_lo;
        logic      rd_hi;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic div_done;
        logic hit_now;
        logic last_way;
        logic found;
        logic need_wb;
        logic last_byte;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: sv/set_assoc_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_unit
// Set-associative write-back cache with use-bit replacement in front of
// an internal byte memory.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_data   (operation, address, data)
//   out      out  out_valid/out_ready  out_data  (read data, flags, way)
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One item at a time.
// Block and set/tag divisions share a restoring divider of D = 16 +
// clog2(MAX_SETS+1) + clog2(MAX_BLOCK_BYTES+1) quotient bits (26);
// memory wrap is a reciprocal multiply. A hit ends the way search; a
// miss searches every way, writes back a dirty victim, then fills the
// block of B bytes. No clearing pass after reset.
// A finished beat waits in the output register; a stalled output holds the
// sequencer in its last state only once the next item has finished too.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_unit
    import sawc_pkg::*;
#(
    parameter int MAX_SETS        = DEF_MAX_SETS,
    parameter int MAX_WAYS        = DEF_MAX_WAYS,
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MEM_BYTES       = DEF_MEM_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    sawc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sawc_dp #(
        .MAX_SETS        (MAX_SETS),
        .MAX_WAYS        (MAX_WAYS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MEM_BYTES       (MEM_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: sv/sawc_ram.sv
// ----------------------------------------------------------------------------
// sawc_ram
// Single-port RAM, one address per cycle, registered read data (old word on a write).
// ----------------------------------------------------------------------------
module sawc_ram
    import sawc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [clog2w(DEPTH)-1:0]  addr,
    input  logic [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

FILE: sv/sawc_div.sv
// ----------------------------------------------------------------------------
// sawc_div
// Restoring divider, one quotient bit per cycle, shared by the block and set/tag divisions.
// ----------------------------------------------------------------------------
module sawc_div
    import sawc_pkg::*;
#(
    parameter int DVW = 26,
    parameter int DSW = 17
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quot,
    output logic [DSW-1:0] rem
);

    localparam int CNTW = $clog2(DVW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DVW-1:0]  q_reg;
    logic [DSW-1:0]  r_reg;
    logic [DSW-1:0]  d_reg;
    logic [DSW:0]    trial;
    logic            fits;

    assign trial = {r_reg, q_reg[DVW-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (32'(cnt_reg) == DVW - 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DVW-2:0], fits};
            // remainder stays below the divisor, so the top bit drops
            r_reg <= fits ? DSW'(trial - {1'b0, d_reg}) : trial[DSW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

FILE: sv/sawc_ctrl.sv
// ----------------------------------------------------------------------------
// sawc_ctrl
// Sequencer: preload, lookup, victim write-back, block fill and word access.
// ----------------------------------------------------------------------------
module sawc_ctrl
    import sawc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_READ, OP_WRITE: state_next = S_BLK_DIV;
                    OP_PRELOAD:        state_next = S_PL_DIV;
                    default:           state_next = S_DONE;
                endcase
            end
            S_PL_DIV:   state_next = S_PL_WAIT;
            S_PL_WAIT:  if (sts.div_done) state_next = S_PL_WR0;
            S_PL_WR0:   state_next = S_PL_WR1;
            S_PL_WR1:   state_next = S_DONE;
            S_BLK_DIV:  state_next = S_BLK_WAIT;
            S_BLK_WAIT: if (sts.div_done) state_next = S_SET_DIV;
            S_SET_DIV:  state_next = S_SET_WAIT;
            S_SET_WAIT: if (sts.div_done) state_next = S_SRCH_RD;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (sts.hit_now || sts.last_way)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_DECIDE:   state_next = S_BRANCH;
            S_BRANCH:
            begin
                priority if (sts.found)
                begin
                    state_next = S_ACC;
                end
                else if (sts.need_wb)
                begin
                    state_next = S_VT_RD;
                end
                else
                begin
                    state_next = S_FL_DIV;
                end
            end
            S_VT_RD:    state_next = S_VT_MUL1;
            S_VT_MUL1:  state_next = S_VT_MUL2;
            S_VT_MUL2:  state_next = S_VT_DIV;
            S_VT_DIV:   state_next = S_VT_WAIT;
            S_VT_WAIT:  if (sts.div_done) state_next = S_WB_RD;
            S_WB_RD:    state_next = S_WB_WR;
            S_WB_WR:    state_next = sts.last_byte ? S_FL_DIV : S_WB_RD;
            S_FL_DIV:   state_next = S_FL_WAIT;
            S_FL_WAIT:  if (sts.div_done) state_next = S_FL_RD;
            S_FL_RD:    state_next = S_FL_WR;
            S_FL_WR:    state_next = sts.last_byte ? S_FL_END : S_FL_RD;
            S_FL_END:   state_next = S_ACC;
            S_ACC:      state_next = (sts.op == OP_READ) ? S_RD1 : S_WR1;
            S_RD1:      state_next = S_RD2;
            S_RD2:      state_next = S_DONE;
            S_WR1:      state_next = S_DONE;
            S_DONE:     if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = DIV_BLOCK;
        cmd.byte_sel = BA_CNT;
        cmd.line_src = SRC_RAM;
        cmd.mem_src  = SRC_RAM;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_PL_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PRE;
            end
            S_PL_WR0:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.mem_src   = SRC_LO;
                cmd.walk_step = 1'b1;
            end
            S_PL_WR1:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.mem_src = SRC_HI;
            end
            S_BLK_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BLOCK;
            end
            S_SET_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SET;
            end
            S_SRCH_CMP: cmd.srch_cmp = 1'b1;
            S_DECIDE:   cmd.decide   = 1'b1;
            S_VT_MUL1:  cmd.vt_mul1  = 1'b1;
            S_VT_MUL2:  cmd.vt_mul2  = 1'b1;
            S_VT_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VICT;
            end
            S_WB_WR:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.mem_src   = SRC_RAM;
                cmd.walk_step = 1'b1;
            end
            S_FL_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FILL;
            end
            S_FL_WR:
            begin
                cmd.line_wr   = 1'b1;
                cmd.line_src  = SRC_RAM;
                cmd.walk_step = 1'b1;
            end
            S_FL_END:   cmd.fill_commit = 1'b1;
            S_ACC:
            begin
                cmd.byte_sel = BA_OFF;
                cmd.line_src = SRC_LO;
                cmd.line_wr  = (sts.op == OP_WRITE);
            end
            S_RD1:
            begin
                cmd.rd_lo    = 1'b1;
                cmd.byte_sel = BA_OFF2;
            end
            S_RD2:      cmd.rd_hi = 1'b1;
            S_WR1:
            begin
                cmd.byte_sel  = BA_OFF2;
                cmd.line_src  = SRC_HI;
                cmd.line_wr   = 1'b1;
                cmd.set_dirty = 1'b1;
            end
            S_DONE:     cmd.out_load = sts.out_free;
            default:    cmd.load_in  = 1'b0;
        endcase
    end

endmodule

FILE: sv/sawc_dp.sv
// ----------------------------------------------------------------------------
// sawc_dp
// Datapath: configuration, line state, tag, line and backing memories,
// divider, memory wrap unit and the result register.
// ----------------------------------------------------------------------------
module sawc_dp
    import sawc_pkg::*;
#(
    parameter int MAX_SETS        = DEF_MAX_SETS,
    parameter int MAX_WAYS        = DEF_MAX_WAYS,
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MEM_BYTES       = DEF_MEM_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts
);

    localparam int LINES    = MAX_SETS * MAX_WAYS;
    localparam int SW       = clog2w(MAX_SETS);
    localparam int WW       = clog2w(MAX_WAYS);
    localparam int LW       = clog2w(LINES);
    localparam int OW       = clog2w(MAX_BLOCK_BYTES);
    localparam int CW       = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int NWW      = $clog2(MAX_WAYS + 1);
    localparam int LBW      = clog2w(LINES * MAX_BLOCK_BYTES);
    localparam int MAW      = clog2w(MEM_BYTES);
    localparam int DSW      = $clog2(MEM_BYTES + 1);
    localparam int P1W      = TAG_W + $clog2(MAX_SETS + 1);
    localparam int VBW      = P1W + $clog2(MAX_BLOCK_BYTES + 1);
    localparam int MBB_EVEN = (MAX_BLOCK_BYTES / 2) * 2;

    // reciprocal of the memory size, exact for any dividend below 2**VBW
    localparam int     MKW    = VBW + clog2w(MEM_BYTES);
    localparam longint MRECIP = ((longint'(1) << MKW) + longint'(MEM_BYTES) - 1)
                                / longint'(MEM_BYTES);
    localparam int     MRW    = VBW + 2;
    localparam int     MPW    = VBW + MRW;

    // configuration
    logic [4:0] sets_cfg_reg;
    logic [2:0] ways_cfg_reg;
    logic [4:0] blk_cfg_reg;

    logic [DSW-1:0] nsets;
    logic [DSW-1:0] bsize;
    logic [NWW-1:0] nways;
    logic [4:0]     blk_even;

    // item and lookup
    op_t              op_reg;
    logic [15:0]      addr_reg;
    logic [15:0]      wdata_reg;
    logic [15:0]      block_reg;
    logic [OW-1:0]    offset_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SW-1:0]    set_reg;
    logic [WW-1:0]    way_reg;
    logic             found_reg;
    logic             free_reg;
    logic [WW-1:0]    freew_reg;
    logic             usefound_reg;
    logic [WW-1:0]    usew_reg;
    logic [P1W-1:0]   p1_reg;
    logic [VBW-1:0]   vbase_reg;
    logic [MAW-1:0]   mptr_reg;
    logic [CW-1:0]    cnt_reg;
    div_sel_t         divsel_reg;

    // results
    logic [15:0] rdata_reg;
    logic        hit_reg;
    logic        rvalid_reg;
    logic        wb_reg;
    logic [15:0] vaddr_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    // line flags, one word of ways per set
    logic [MAX_WAYS-1:0] valid_reg [MAX_SETS];
    logic [MAX_WAYS-1:0] dirty_reg [MAX_SETS];
    logic [MAX_WAYS-1:0] use_reg   [MAX_SETS];

    logic [LW-1:0]    line_idx;
    logic [OW-1:0]    off2;
    logic [OW-1:0]    byte_idx;
    logic [LBW-1:0]   line_addr;
    logic [TAG_W-1:0] tag_rdata;
    logic [7:0]       line_rdata;
    logic [7:0]       mem_rdata;
    logic [7:0]       line_wdata;
    logic [7:0]       mem_wdata;
    logic             match;
    logic             last_way;
    logic             out_free;

    logic [VBW-1:0] div_dvd;
    logic [DSW-1:0] div_dvs;
    logic           div_done;
    logic [VBW-1:0] div_quot;
    logic [DSW-1:0] div_rem;

    // memory wrap unit
    logic           mod_start;
    logic           div_go;
    logic [VBW-1:0] mx_reg;
    logic [VBW-1:0] mq_reg;
    logic           mq_go_reg;
    logic           mod_done_reg;
    logic [MPW-1:0] mprod;
    logic [VBW-1:0] mod_rem;

    // clamp the registers to the supported geometry
    assign blk_even = {blk_cfg_reg[4:1], 1'b0};

    always_comb
    begin
        priority if (sets_cfg_reg == '0)
        begin
            nsets = DSW'(1);
        end
        else if (32'(sets_cfg_reg) > MAX_SETS)
        begin
            nsets = DSW'(MAX_SETS);
        end
        else
        begin
            nsets = DSW'(sets_cfg_reg);
        end

        priority if (ways_cfg_reg == '0)
        begin
            nways = NWW'(1);
        end
        else if (32'(ways_cfg_reg) > MAX_WAYS)
        begin
            nways = NWW'(MAX_WAYS);
        end
        else
        begin
            nways = NWW'(ways_cfg_reg);
        end

        priority if (blk_even < 5'd2)
        begin
            bsize = DSW'(2);
        end
        else if (32'(blk_even) > MBB_EVEN)
        begin
            bsize = DSW'(MBB_EVEN);
        end
        else
        begin
            bsize = DSW'(blk_even);
        end
    end

    assign line_idx = LW'(32'(set_reg) * MAX_WAYS + 32'(way_reg));
    assign off2     = (32'(offset_reg) + 1 >= 32'(bsize)) ? '0 : OW'(offset_reg + 1'b1);

    always_comb
    begin
        unique case (cmd.byte_sel)
            BA_OFF:  byte_idx = offset_reg;
            BA_OFF2: byte_idx = off2;
            default: byte_idx = cnt_reg[OW-1:0];
        endcase
    end

    assign line_addr = LBW'(32'(line_idx) * MAX_BLOCK_BYTES + 32'(byte_idx));

    always_comb
    begin
        unique case (cmd.line_src)
            SRC_LO:  line_wdata = wdata_reg[7:0];
            SRC_HI:  line_wdata = wdata_reg[15:8];
            default: line_wdata = mem_rdata;
        endcase
        unique case (cmd.mem_src)
            SRC_LO:  mem_wdata = wdata_reg[7:0];
            SRC_HI:  mem_wdata = wdata_reg[15:8];
            default: mem_wdata = line_rdata;
        endcase
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_BLOCK:
            begin
                div_dvd = VBW'(addr_reg);
                div_dvs = bsize;
            end
            DIV_SET:
            begin
                div_dvd = VBW'(block_reg);
                div_dvs = nsets;
            end
            DIV_PRE:
            begin
                div_dvd = VBW'(addr_reg);
                div_dvs = DSW'(MEM_BYTES);
            end
            DIV_FILL:
            begin
                div_dvd = VBW'(addr_reg - 16'(offset_reg));
                div_dvs = DSW'(MEM_BYTES);
            end
            default:
            begin
                div_dvd = vbase_reg;
                div_dvs = DSW'(MEM_BYTES);
            end
        endcase
    end

    // memory wrap goes to the reciprocal unit, the rest to the divider
    assign mod_start = cmd.div_start && (cmd.div_sel != DIV_BLOCK) && (cmd.div_sel != DIV_SET);
    assign div_go    = cmd.div_start && !mod_start;
    assign mprod     = MPW'(mx_reg) * MPW'(MRECIP);
    assign mod_rem   = mx_reg - VBW'(mq_reg * VBW'(MEM_BYTES));

    assign match    = valid_reg[set_reg][way_reg] && (tag_rdata == tag_reg);
    assign last_way = (32'(way_reg) + 1 >= 32'(nways));
    assign out_free = !out_valid_reg || out_ready;

    assign sts.op        = op_reg;
    assign sts.div_done  = div_done || mod_done_reg;
    assign sts.hit_now   = match;
    assign sts.last_way  = last_way;
    assign sts.found     = found_reg;
    assign sts.need_wb   = !found_reg && !free_reg && dirty_reg[set_reg][way_reg];
    assign sts.last_byte = (32'(cnt_reg) + 1 >= 32'(bsize));
    assign sts.out_free  = out_free;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_cfg_reg  <= SETS_RESET;
            ways_cfg_reg  <= WAYS_RESET;
            blk_cfg_reg   <= BLOCK_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            usefound_reg  <= 1'b0;
            mq_go_reg     <= 1'b0;
            mod_done_reg  <= 1'b0;
            for (int i = 0; i < MAX_SETS; i++)
            begin
                valid_reg[i] <= '0;
                dirty_reg[i] <= '0;
                use_reg[i]   <= '0;
            end
        end
        else
        begin
            mq_go_reg    <= mod_start;
            mod_done_reg <= mq_go_reg;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SETS:  sets_cfg_reg <= cfg_wdata;
                    REG_WAYS:  ways_cfg_reg <= cfg_wdata[2:0];
                    REG_BLOCK: blk_cfg_reg  <= cfg_wdata;
                    default:   sets_cfg_reg <= sets_cfg_reg;
                endcase
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load_in)
            begin
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
                usefound_reg <= 1'b0;
            end

            if (cmd.srch_cmp)
            begin
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    if (!valid_reg[set_reg][way_reg] && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                    if (valid_reg[set_reg][way_reg] && !use_reg[set_reg][way_reg]
                        && !usefound_reg)
                    begin
                        usefound_reg <= 1'b1;
                    end
                end
            end

            if (cmd.decide)
            begin
                if (found_reg)
                begin
                    use_reg[set_reg][way_reg] <= 1'b1;
                end
                else if (!free_reg && !usefound_reg)
                begin
                    // every use bit set: clear the whole set
                    for (int i = 0; i < MAX_WAYS; i++)
                    begin
                        if (i < 32'(nways))
                        begin
                            use_reg[set_reg][i] <= 1'b0;
                        end
                    end
                end
            end

            if (cmd.fill_commit)
            begin
                valid_reg[set_reg][way_reg] <= 1'b1;
                use_reg[set_reg][way_reg]   <= 1'b1;
                dirty_reg[set_reg][way_reg] <= 1'b0;
            end

            if (cmd.set_dirty)
            begin
                dirty_reg[set_reg][way_reg] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= op_t'(in_data.operation);
            addr_reg   <= in_data.address;
            wdata_reg  <= in_data.write_data;
            way_reg    <= '0;
            rdata_reg  <= '0;
            hit_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
            wb_reg     <= 1'b0;
            vaddr_reg  <= '0;
        end

        if (cmd.div_start)
        begin
            divsel_reg <= cmd.div_sel;
            cnt_reg    <= '0;
        end

        if (mod_start)
        begin
            mx_reg <= div_dvd;
        end
        if (mq_go_reg)
        begin
            mq_reg <= VBW'(mprod >> MKW);
        end

        if (div_done || mod_done_reg)
        begin
            unique case (divsel_reg)
                DIV_BLOCK:
                begin
                    block_reg  <= div_quot[15:0];
                    offset_reg <= div_rem[OW-1:0];
                end
                DIV_SET:
                begin
                    tag_reg <= div_quot[TAG_W-1:0];
                    set_reg <= div_rem[SW-1:0];
                end
                DIV_VICT:
                begin
                    mptr_reg  <= mod_rem[MAW-1:0];
                    wb_reg    <= 1'b1;
                    vaddr_reg <= vbase_reg[15:0];
                end
                default: mptr_reg <= mod_rem[MAW-1:0];
            endcase
        end

        if (cmd.srch_cmp && !match)
        begin
            if (!valid_reg[set_reg][way_reg] && !free_reg)
            begin
                freew_reg <= way_reg;
            end
            if (valid_reg[set_reg][way_reg] && !use_reg[set_reg][way_reg] && !usefound_reg)
            begin
                usew_reg <= way_reg;
            end
            if (!last_way)
            begin
                way_reg <= way_reg + 1'b1;
            end
        end

        if (cmd.decide)
        begin
            priority if (found_reg)
            begin
                hit_reg <= 1'b1;
            end
            else if (free_reg)
            begin
                way_reg <= freew_reg;
            end
            else if (usefound_reg)
            begin
                way_reg    <= usew_reg;
                rvalid_reg <= 1'b1;
            end
            else
            begin
                way_reg    <= '0;
                rvalid_reg <= 1'b1;
            end
        end

        if (cmd.vt_mul1)
        begin
            p1_reg <= P1W'(tag_rdata) * P1W'(nsets) + P1W'(set_reg);
        end
        if (cmd.vt_mul2)
        begin
            vbase_reg <= VBW'(p1_reg) * VBW'(bsize);
        end

        if (cmd.walk_step)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            mptr_reg <= (32'(mptr_reg) == MEM_BYTES - 1) ? '0 : MAW'(mptr_reg + 1'b1);
        end

        if (cmd.rd_lo)
        begin
            rdata_reg[7:0] <= line_rdata;
        end
        if (cmd.rd_hi)
        begin
            rdata_reg[15:8] <= line_rdata;
        end

        if (cmd.out_load)
        begin
            out_data_reg.read_data            <= rdata_reg;
            out_data_reg.hit                  <= hit_reg;
            out_data_reg.replaced_valid       <= rvalid_reg;
            out_data_reg.wrote_back           <= wb_reg;
            out_data_reg.victim_block_address <= vaddr_reg;
            out_data_reg.way_used             <= 2'(way_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sawc_div #(
        .DVW (VBW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    sawc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.fill_commit),
        .addr  (line_idx),
        .wdata (tag_reg),
        .rdata (tag_rdata)
    );

    sawc_ram #(
        .WIDTH (8),
        .DEPTH (LINES * MAX_BLOCK_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.line_wr),
        .addr  (line_addr),
        .wdata (line_wdata),
        .rdata (line_rdata)
    );

    sawc_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem_ram (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .addr  (mptr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

FILE: verif/tb_set_assoc_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_writeback_cache_unit
// Self-checking bench for the set-associative write-back cache. A predictor
// keeps its own copy of the tags, flags, line bytes and backing memory. It
// also tracks which bytes hold written data, so that no access reads storage
// that was never written. Directed cases come first. Random phases follow
// over several geometries and idle mixes, then a long output hold-off.
// ----------------------------------------------------------------------------
module tb_set_assoc_writeback_cache_unit;
    import sawc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS_MAX  = DEF_MAX_SETS;
    localparam int NWAYS_MAX  = DEF_MAX_WAYS;
    localparam int BLK_MAX    = DEF_MAX_BLOCK_BYTES;
    localparam int LINES      = NSETS_MAX * NWAYS_MAX;
    localparam int CYCLE_CAP  = 5000000;
    localparam int DRAIN_WAIT = 8;

    localparam int ACC_OK      = 0;
    localparam int ACC_PRELOAD = 1;
    localparam int ACC_REJECT  = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    set_assoc_writeback_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [4:0]  sets_reg;
    logic [2:0]  ways_reg;
    logic [4:0]  block_reg;
    bit          ln_valid [LINES];
    bit          ln_dirty [LINES];
    bit          ln_use   [LINES];
    logic [15:0] ln_tag   [LINES];
    logic [7:0]  ln_byte  [LINES*BLK_MAX];
    bit          ln_known [LINES*BLK_MAX];
    logic [7:0]  mem_byte [65536];
    bit          mem_known[65536];

    out_item_t   expected_beats[$];
    int          mismatches;
    int          cycles;
    int          items_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          win_base;
    int          win_size;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int geo_sets();
        if (sets_reg < 1) return 1;
        if (sets_reg > NSETS_MAX) return NSETS_MAX;
        return sets_reg;
    endfunction

    function automatic int geo_ways();
        if (ways_reg < 1) return 1;
        if (ways_reg > NWAYS_MAX) return NWAYS_MAX;
        return ways_reg;
    endfunction

    function automatic int geo_block();
        int b;
        b = block_reg & ~1;
        if (b < 2) b = 2;
        if (b > BLK_MAX) b = BLK_MAX;
        return b;
    endfunction

    // hit way, else first invalid, else first clear use bit, else way 0
    function automatic int pick_way(input int base, input int nw, input logic [15:0] tg,
                                    output bit found);
        found = 1'b0;
        for (int i = 0; i < nw; i++)
            if (ln_valid[base+i] && ln_tag[base+i] == tg)
            begin
                found = 1'b1;
                return i;
            end
        for (int i = 0; i < nw; i++)
            if (!ln_valid[base+i]) return i;
        for (int i = 0; i < nw; i++)
            if (!ln_use[base+i]) return i;
        return 0;
    endfunction

    // would this access touch storage never written?
    function automatic int classify(input op_t op, input logic [15:0] a);
        int bs, ns, blk, off, off2, st, base, w, ln;
        logic [15:0] tg;
        bit found;
        bs   = geo_block();
        ns   = geo_sets();
        blk  = a / bs;
        off  = a % bs;
        off2 = (off + 1 >= bs) ? 0 : off + 1;
        st   = blk % ns;
        tg   = 16'(blk / ns);
        base = st * NWAYS_MAX;
        w    = pick_way(base, geo_ways(), tg, found);
        ln   = base + w;
        if (found)
        begin
            if (op == OP_READ && !(ln_known[ln*BLK_MAX+off] && ln_known[ln*BLK_MAX+off2]))
                return ACC_REJECT;
            return ACC_OK;
        end
        if (ln_valid[ln] && ln_dirty[ln])
            for (int i = 0; i < bs; i++)
                if (!ln_known[ln*BLK_MAX+i]) return ACC_REJECT;
        for (int i = 0; i < bs; i++)
            if (!mem_known[16'(a - off + i)]) return ACC_PRELOAD;
        return ACC_OK;
    endfunction

    function automatic out_item_t model_access(input in_item_t it);
        out_item_t r;
        op_t op;
        int bs, ns, nw, blk, off, off2, st, base, w, ln, vb;
        logic [15:0] tg, a;
        bit found;
        r  = '0;
        op = op_t'(it.operation);
        a  = it.address;
        if (op == OP_PRELOAD)
        begin
            mem_byte[a] = it.write_data[7:0];
            mem_byte[16'(a + 1)] = it.write_data[15:8];
            mem_known[a] = 1'b1;
            mem_known[16'(a + 1)] = 1'b1;
        end
        else if (op == OP_READ || op == OP_WRITE)
        begin
            bs   = geo_block();
            ns   = geo_sets();
            nw   = geo_ways();
            blk  = a / bs;
            off  = a % bs;
            off2 = (off + 1 >= bs) ? 0 : off + 1;
            st   = blk % ns;
            tg   = 16'(blk / ns);
            base = st * NWAYS_MAX;
            w    = pick_way(base, nw, tg, found);
            ln   = base + w;
            if (found)
            begin
                r.hit = 1'b1;
                ln_use[ln] = 1'b1;
            end
            else
            begin
                // every use bit set: clear the lot, way 0 is the victim
                if (ln_valid[ln] && ln_use[ln])
                    for (int i = 0; i < nw; i++) ln_use[base+i] = 1'b0;
                if (ln_valid[ln] && ln_dirty[ln])
                begin
                    vb = (int'(ln_tag[ln]) * ns + st) * bs;
                    for (int i = 0; i < bs; i++)
                    begin
                        mem_byte[16'(vb + i)]  = ln_byte[ln*BLK_MAX+i];
                        mem_known[16'(vb + i)] = ln_known[ln*BLK_MAX+i];
                    end
                    r.wrote_back = 1'b1;
                    r.victim_block_address = 16'(vb);
                end
                r.replaced_valid = ln_valid[ln];
                for (int i = 0; i < bs; i++)
                begin
                    ln_byte[ln*BLK_MAX+i]  = mem_byte[16'(a - off + i)];
                    ln_known[ln*BLK_MAX+i] = 1'b1;
                end
                ln_valid[ln] = 1'b1;
                ln_use[ln]   = 1'b1;
                ln_tag[ln]   = tg;
                ln_dirty[ln] = 1'b0;
            end
            r.way_used = 2'(w);
            if (op == OP_READ)
                r.read_data = {ln_byte[ln*BLK_MAX+off2], ln_byte[ln*BLK_MAX+off]};
            else
            begin
                ln_byte[ln*BLK_MAX+off]   = it.write_data[7:0];
                ln_byte[ln*BLK_MAX+off2]  = it.write_data[15:8];
                ln_known[ln*BLK_MAX+off]  = 1'b1;
                ln_known[ln*BLK_MAX+off2] = 1'b1;
                ln_dirty[ln] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [15:0] a, input logic [15:0] d);
        in_item_t it;
        it.operation  = op;
        it.address    = a;
        it.write_data = d;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        expected_beats.push_back(model_access(it));
        items_sent++;
    endtask

    // cached access, preloading its block first where memory is blank
    task automatic cached_access(input op_t op, input logic [15:0] a, input logic [15:0] d,
                                 output bit sent);
        int verdict;
        logic [15:0] base;
        sent    = 1'b0;
        verdict = classify(op, a);
        if (verdict == ACC_PRELOAD)
        begin
            base = 16'(a - a % geo_block());
            for (int k = 0; k < geo_block(); k += 2)
                send_item(OP_PRELOAD, 16'(base + k), 16'($urandom));
            verdict = classify(op, a);
        end
        if (verdict == ACC_OK)
        begin
            send_item(op, a, d);
            sent = 1'b1;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [4:0] s, input logic [4:0] w, input logic [4:0] b);
        logic [4:0] vals [3];
        logic [CFG_IDX_W-1:0] idx [3];
        vals = '{s, w, b};
        idx  = '{REG_SETS, REG_WAYS, REG_BLOCK};
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        sets_reg  = s;
        ways_reg  = w[2:0];
        block_reg = b;
    endtask

    // runs until about count items of any kind have gone in
    task automatic run_random(input int count);
        int first, r;
        bit sent;
        logic [15:0] a;
        first = items_sent;
        while (items_sent - first < count)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_item(OP_PRELOAD, 16'($urandom), 16'($urandom));
            else if (r < 11)
                send_item(OP_NONE, 16'($urandom), 16'($urandom));
            else
            begin
                sent = 1'b0;
                for (int t = 0; t < 16 && !sent; t++)
                begin
                    if ($urandom_range(99) < 75)
                        a = 16'(win_base + $urandom_range(win_size - 1));
                    else
                        a = 16'($urandom);
                    cached_access($urandom_range(1) ? OP_WRITE : OP_READ, a,
                                  16'($urandom), sent);
                end
                if (!sent)
                    send_item(OP_PRELOAD, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        bit sent;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // direct mapped, one set, 2-byte blocks
        send_item(OP_PRELOAD, 16'h0000, 16'hA55A);
        cached_access(OP_READ, 16'h0000, 16'h0000, sent);
        cached_access(OP_WRITE, 16'h0000, 16'hFFFF, sent);
        cached_access(OP_READ, 16'h0000, 16'h0000, sent);
        cached_access(OP_READ, 16'h0002, 16'h0000, sent);   // dirty eviction
        cached_access(OP_WRITE, 16'hFFFE, 16'h1234, sent);
        cached_access(OP_READ, 16'h0001, 16'h0000, sent);   // odd byte wraps in block
        send_item(OP_PRELOAD, 16'hFFFF, 16'hBEEF);          // memory wrap
        send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
        cached_access(OP_READ, 16'hFFFE, 16'h0000, sent);
        // largest geometry: fill one set past its ways to clear use bits
        set_geometry(5'd16, 5'd4, 5'd16);
        cached_access(OP_READ, 16'h000F, 16'h0000, sent);
        for (int k = 1; k < 6; k++)
            cached_access(k[0] ? OP_WRITE : OP_READ, 16'(k * 256), 16'($urandom), sent);
        cached_access(OP_WRITE, 16'hFFFF, 16'h5AA5, sent);
        cached_access(OP_READ, 16'h0100, 16'h0000, sent);
        send_item(OP_PRELOAD, 16'h0100, 16'h0F0F);          // goes stale under the cache
        cached_access(OP_READ, 16'h0100, 16'h0000, sent);
    endtask

    task automatic test_geometry_phases();
        logic [4:0] geo [12][3];
        geo = '{'{5'd1, 5'd1, 5'd2}, '{5'd16, 5'd4, 5'd16}, '{5'd0, 5'd0, 5'd0},
                '{5'd31, 5'd7, 5'd31}, '{5'd4, 5'd2, 5'd6}, '{5'd17, 5'd5, 5'd17},
                '{5'd2, 5'd3, 5'd8}, '{5'd8, 5'd4, 5'd3}, '{5'd1, 5'd4, 5'd16},
                '{5'd16, 5'd1, 5'd1}, '{5'd5, 5'd2, 5'd10}, '{5'd3, 5'd3, 5'd14}};
        for (int p = 0; p < 12; p++)
        begin
            set_geometry(geo[p][0], geo[p][1], geo[p][2]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            win_size = 64 << $urandom_range(5);
            win_base = $urandom_range(65535);
            run_random(85);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 800;
        win_size       = 256;
        win_base       = $urandom_range(65535);
        run_random(30);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", out_data);
            end
            else
            begin
                out_item_t exp_beat;
                exp_beat = expected_beats.pop_front();
                if (out_data.read_data !== exp_beat.read_data ||
                    out_data.hit !== exp_beat.hit ||
                    out_data.replaced_valid !== exp_beat.replaced_valid ||
                    out_data.wrote_back !== exp_beat.wrote_back ||
                    out_data.victim_block_address !== exp_beat.victim_block_address ||
                    out_data.way_used !== exp_beat.way_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %p, got %p", exp_beat, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_set_assoc_writeback_cache_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SETS;
        cfg_wdata      = '0;
        mismatches     = 0;
        cycles         = 0;
        items_sent     = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        win_base       = 0;
        win_size       = 256;
        sets_reg       = SETS_RESET;
        ways_reg       = WAYS_RESET;
        block_reg      = BLOCK_RESET;
        for (int i = 0; i < LINES; i++)
        begin
            ln_valid[i] = 1'b0;
            ln_dirty[i] = 1'b0;
            ln_use[i]   = 1'b0;
            ln_tag[i]   = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_geometry_phases();
        test_backpressure();
        wait_idle();

        if (mismatches == 0)
            $display("tb_set_assoc_writeback_cache_unit: done, clean");
        else
            $display("tb_set_assoc_writeback_cache_unit: done, errors");
        $finish;
    end

endmodule
